@@ hdl/mlaa_pkg.sv @@
// Shared types and constants of the level alarm annunciator.
`default_nettype none
package mlaa_pkg;

  localparam int unsigned NumChannelsDef = 4;
  localparam int unsigned SampleBitsDef  = 10;

  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned ChannelW  = 2;
  localparam int unsigned LedW      = 4;
  localparam int unsigned StatesW   = 8;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned BlinkW    = 8;

  localparam int unsigned RefSampleBits  = 10;
  localparam int unsigned AlarmThrRef    = 768;
  localparam int unsigned ExitThrRef     = 665;
  localparam int unsigned TimeoutReset   = 2000;
  localparam int unsigned BlinkPerReset  = 5;

  typedef enum logic [OpcodeW-1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_ACK    = 2'd2
  } mlaa_op_e;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_ALARM    = 2'd1,
    MODE_ATTENDED = 2'd2
  } mlaa_mode_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_ALARM_THR = 2'd0,
    CFG_EXIT_THR  = 2'd1,
    CFG_TIMEOUT   = 2'd2,
    CFG_BLINK_PER = 2'd3
  } mlaa_cfg_e;

  typedef struct packed {
    logic [ThrW-1:0]   alarm_thr;
    logic [ThrW-1:0]   exit_thr;
    logic [CountW-1:0] timeout;
    logic [BlinkW-1:0] blink_per;
  } mlaa_cfg_t;

  typedef struct packed {
    logic [LedW-1:0]    green;
    logic [LedW-1:0]    red;
    logic [StatesW-1:0] states;
    logic               buzz;
  } mlaa_result_t;

endpackage
`default_nettype wire

@@ hdl/mlaa_cfg_regs.sv @@
// Configuration register file: thresholds, attend timeout and blink period.
`default_nettype none
module mlaa_cfg_regs #(
  parameter int unsigned SAMPLE_BITS = mlaa_pkg::SampleBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mlaa_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [mlaa_pkg::CfgDataW-1:0] cfg_wdata_i,
  output mlaa_pkg::mlaa_cfg_t                cfg_o
);
  import mlaa_pkg::*;

  localparam int unsigned AlarmRst = (SAMPLE_BITS >= RefSampleBits) ?
      (AlarmThrRef << (SAMPLE_BITS - RefSampleBits)) :
      (AlarmThrRef >> (RefSampleBits - SAMPLE_BITS));
  localparam int unsigned ExitRst = (SAMPLE_BITS >= RefSampleBits) ?
      (ExitThrRef << (SAMPLE_BITS - RefSampleBits)) :
      (ExitThrRef >> (RefSampleBits - SAMPLE_BITS));

  logic [SAMPLE_BITS-1:0] alarm_thr_q, exit_thr_q;
  logic [CountW-1:0]      timeout_q;
  logic [BlinkW-1:0]      blink_per_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_thr_q <= SAMPLE_BITS'(AlarmRst);
      exit_thr_q  <= SAMPLE_BITS'(ExitRst);
      timeout_q   <= CountW'(TimeoutReset);
      blink_per_q <= BlinkW'(BlinkPerReset);
    end else if (cfg_we_i) begin
      case (mlaa_cfg_e'(cfg_addr_i))
        CFG_ALARM_THR: alarm_thr_q <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_EXIT_THR:  exit_thr_q  <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i[CountW-1:0];
        CFG_BLINK_PER: blink_per_q <= cfg_wdata_i[BlinkW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.alarm_thr = ThrW'(alarm_thr_q);
  assign cfg_o.exit_thr  = ThrW'(exit_thr_q);
  assign cfg_o.timeout   = timeout_q;
  assign cfg_o.blink_per = blink_per_q;

endmodule
`default_nettype wire

@@ hdl/mlaa_core.sv @@
// Channel state, counters, blink divider and result encoding.
`default_nettype none
module mlaa_core #(
  parameter int unsigned NUM_CHANNELS = mlaa_pkg::NumChannelsDef,
  parameter int unsigned SAMPLE_BITS  = mlaa_pkg::SampleBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic [mlaa_pkg::OpcodeW-1:0]  opcode_i,
  input  wire logic [mlaa_pkg::ChannelW-1:0] channel_i,
  input  wire logic [SAMPLE_BITS-1:0]        sample_i,
  input  mlaa_pkg::mlaa_cfg_t                cfg_i,
  output mlaa_pkg::mlaa_result_t             result_o
);
  import mlaa_pkg::*;

  localparam int unsigned Shown = (NUM_CHANNELS < LedW) ? NUM_CHANNELS : LedW;

  mlaa_mode_e        mode_q [NUM_CHANNELS];
  mlaa_mode_e        mode_d [NUM_CHANNELS];
  logic [CountW-1:0] cnt_q  [NUM_CHANNELS];
  logic [CountW-1:0] cnt_d  [NUM_CHANNELS];
  logic [BlinkW-1:0] blink_cnt_q, blink_cnt_d;
  logic              phase_q, phase_d;
  logic [ThrW-1:0]   sample_ext;

  assign sample_ext = ThrW'(sample_i);

  always_comb begin
    blink_cnt_d = blink_cnt_q;
    phase_d     = phase_q;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      mode_d[c] = mode_q[c];
      cnt_d[c]  = cnt_q[c];
    end
    case (mlaa_op_e'(opcode_i))
      OP_SAMPLE: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (32'(channel_i) == c) begin
            if (sample_ext > cfg_i.alarm_thr) begin
              if (mode_q[c] != MODE_ATTENDED) mode_d[c] = MODE_ALARM;
            end else if (sample_ext < cfg_i.exit_thr) begin
              mode_d[c] = MODE_NORMAL;
            end
          end
        end
      end
      OP_TICK: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (mode_q[c] == MODE_ATTENDED && cnt_q[c] >= cfg_i.timeout) begin
            mode_d[c] = MODE_ALARM;
          end
          if (cnt_q[c] != {CountW{1'b1}}) cnt_d[c] = cnt_q[c] + CountW'(1);
        end
        if (blink_cnt_q >= cfg_i.blink_per) begin
          phase_d     = ~phase_q;
          blink_cnt_d = BlinkW'(1);
        end else if (blink_cnt_q != {BlinkW{1'b1}}) begin
          blink_cnt_d = blink_cnt_q + BlinkW'(1);
        end
      end
      OP_ACK: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (mode_q[c] == MODE_ALARM) begin
            mode_d[c] = MODE_ATTENDED;
            cnt_d[c]  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        mode_q[c] <= MODE_NORMAL;
        cnt_q[c]  <= '0;
      end
      blink_cnt_q <= '0;
      phase_q     <= 1'b0;
    end else if (adv_i) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        mode_q[c] <= mode_d[c];
        cnt_q[c]  <= cnt_d[c];
      end
      blink_cnt_q <= blink_cnt_d;
      phase_q     <= phase_d;
    end
  end

  always_comb begin
    result_o = '0;
    for (int c = 0; c < Shown; c++) begin
      result_o.green[c] = (mode_d[c] == MODE_NORMAL) || (mode_d[c] == MODE_ATTENDED);
      result_o.red[c]   = (mode_d[c] == MODE_ATTENDED) ||
                          ((mode_d[c] == MODE_ALARM) && phase_d);
      result_o.states[2*c +: 2] = mode_d[c];
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (mode_d[c] == MODE_ALARM) result_o.buzz = 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ hdl/multichannel_level_alarm_annunciator.sv @@
// Four-channel level alarm annunciator with acknowledge and re-alarm timeout.
// An accepted item waits in the input register until its result is registered.
// Throughput: one item per cycle; the input register and the result register
// form a two-stage pipeline that advances whenever the result slot is free.
// Reset: clears all channels to normal, counters and blink phase to zero,
// and loads the configuration registers with their defaults.
`default_nettype none
module multichannel_level_alarm_annunciator #(
  parameter int unsigned NUM_CHANNELS = mlaa_pkg::NumChannelsDef,
  parameter int unsigned SAMPLE_BITS  = mlaa_pkg::SampleBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mlaa_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [mlaa_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [mlaa_pkg::OpcodeW-1:0]  opcode_i,
  input  wire logic [mlaa_pkg::ChannelW-1:0] channel_i,
  input  wire logic [SAMPLE_BITS-1:0]        sample_value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [mlaa_pkg::LedW-1:0]     green_leds_o,
  output      logic [mlaa_pkg::LedW-1:0]     red_leds_o,
  output      logic [mlaa_pkg::StatesW-1:0]  channel_states_o,
  output      logic                          buzzer_request_o
);
  import mlaa_pkg::*;

  mlaa_cfg_t              cfg;
  mlaa_result_t           result, res_q;
  logic                   s1_valid_q, out_valid_q;
  logic [OpcodeW-1:0]     s1_opcode_q;
  logic [ChannelW-1:0]    s1_channel_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   adv, in_accept;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  mlaa_cfg_regs #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  mlaa_core #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .opcode_i (s1_opcode_q),
    .channel_i(s1_channel_q),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_opcode_q  <= opcode_i;
      s1_channel_q <= channel_i;
      s1_sample_q  <= sample_value_i;
    end
    if (adv) begin
      res_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign green_leds_o     = res_q.green;
  assign red_leds_o       = res_q.red;
  assign channel_states_o = res_q.states;
  assign buzzer_request_o = res_q.buzz;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the level alarm annunciator: queued stimulus, clocked driver and checker.
module tb;
  import mlaa_pkg::*;

  localparam int unsigned SmpW = SampleBitsDef;
  localparam logic [OpcodeW-1:0] OpUnused = 2'd3;
  localparam int unsigned CycleLimit = 500000;

  typedef struct packed {
    logic [OpcodeW-1:0]  op;
    logic [ChannelW-1:0] ch;
    logic [SmpW-1:0]     val;
  } panel_item_t;

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OpcodeW-1:0]  opcode_i;
  logic [ChannelW-1:0] channel_i;
  logic [SmpW-1:0]     sample_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [LedW-1:0]     green_leds_o;
  logic [LedW-1:0]     red_leds_o;
  logic [StatesW-1:0]  channel_states_o;
  logic                buzzer_request_o;

  multichannel_level_alarm_annunciator dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .channel_i       (channel_i),
    .sample_value_i  (sample_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .green_leds_o    (green_leds_o),
    .red_leds_o      (red_leds_o),
    .channel_states_o(channel_states_o),
    .buzzer_request_o(buzzer_request_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state and configuration copy
  logic [SmpW-1:0]   alarm_thr;
  logic [SmpW-1:0]   exit_thr;
  logic [15:0]       attend_to;
  logic [7:0]        blink_per;
  mlaa_mode_e        mode [NumChannelsDef];
  logic [15:0]       ack_cnt [NumChannelsDef];
  logic [7:0]        blink_cnt;
  logic              blink_ph;

  panel_item_t  item_q [$];
  mlaa_result_t panel_q [$];
  mlaa_result_t want;
  logic         in_taken;
  int unsigned  send_idle;
  int unsigned  recv_idle;
  int unsigned  errors;
  int unsigned  cycles;
  int unsigned  n_items;
  int unsigned  n_checked;
  int unsigned  n_writes;
  int unsigned  n_realarm;
  int unsigned  n_buzz;

  function automatic mlaa_result_t next_panel(logic [OpcodeW-1:0] op,
                                              logic [ChannelW-1:0] ch,
                                              logic [SmpW-1:0] val);
    mlaa_result_t r;
    int c;
    r = '0;
    case (op)
      OP_SAMPLE: begin
        if (val > alarm_thr) begin
          if (mode[ch] != MODE_ATTENDED) mode[ch] = MODE_ALARM;
        end else if (val < exit_thr) begin
          mode[ch] = MODE_NORMAL;
        end
      end
      OP_TICK: begin
        for (c = 0; c < NumChannelsDef; c++) begin
          if (mode[c] == MODE_ATTENDED && ack_cnt[c] >= attend_to) begin
            mode[c] = MODE_ALARM;
            n_realarm++;
          end
        end
        if (blink_cnt >= blink_per) begin
          blink_ph  = ~blink_ph;
          blink_cnt = '0;
        end
        if (blink_cnt != 8'hFF) blink_cnt = blink_cnt + 8'd1;
        for (c = 0; c < NumChannelsDef; c++) begin
          if (ack_cnt[c] != 16'hFFFF) ack_cnt[c] = ack_cnt[c] + 16'd1;
        end
      end
      OP_ACK: begin
        for (c = 0; c < NumChannelsDef; c++) begin
          if (mode[c] == MODE_ALARM) begin
            mode[c]    = MODE_ATTENDED;
            ack_cnt[c] = '0;
          end
        end
      end
      default: ;
    endcase
    for (c = 0; c < NumChannelsDef; c++) begin
      if (mode[c] == MODE_NORMAL || mode[c] == MODE_ATTENDED) r.green[c] = 1'b1;
      if (mode[c] == MODE_ATTENDED || (mode[c] == MODE_ALARM && blink_ph)) r.red[c] = 1'b1;
      if (mode[c] == MODE_ALARM) r.buzz = 1'b1;
      r.states[2*c +: 2] = mode[c];
    end
    return r;
  endfunction

  // checker, predictor and config tracking
  always @(posedge clk) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (panel_q.size() == 0) begin
          $error("result with no expectation pending");
          errors++;
        end else begin
          want = panel_q.pop_front();
          n_checked++;
          if (buzzer_request_o) n_buzz++;
          if (green_leds_o !== want.green) begin
            $error("green_leds: expected %h, got %h", want.green, green_leds_o);
            errors++;
          end
          if (red_leds_o !== want.red) begin
            $error("red_leds: expected %h, got %h", want.red, red_leds_o);
            errors++;
          end
          if (channel_states_o !== want.states) begin
            $error("channel_states: expected %h, got %h", want.states, channel_states_o);
            errors++;
          end
          if (buzzer_request_o !== want.buzz) begin
            $error("buzzer_request: expected %h, got %h", want.buzz, buzzer_request_o);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_ALARM_THR: alarm_thr = cfg_wdata_i[SmpW-1:0];
          CFG_EXIT_THR:  exit_thr  = cfg_wdata_i[SmpW-1:0];
          CFG_TIMEOUT:   attend_to = cfg_wdata_i[15:0];
          CFG_BLINK_PER: blink_per = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        panel_q.push_back(next_panel(opcode_i, channel_i, sample_value_i));
      end
    end
  end

  // item driver; the head of item_q stays queued until it is taken
  always @(negedge clk) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
      if (!in_valid_i || in_taken) begin
        if (in_taken) item_q.delete(0);
        if (item_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid_i     <= 1'b1;
          opcode_i       <= item_q[0].op;
          channel_i      <= item_q[0].ch;
          sample_value_i <= item_q[0].val;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_item(logic [OpcodeW-1:0] op, logic [ChannelW-1:0] ch,
                           logic [SmpW-1:0] val);
    panel_item_t it;
    it.op  = op;
    it.ch  = ch;
    it.val = val;
    item_q.push_back(it);
    n_items++;
  endtask

  task automatic write_reg(mlaa_cfg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(negedge clk);
    cfg_we_i    = 1'b0;
    n_writes++;
  endtask

  // upper data bits are junk for the narrow registers
  task automatic set_config(int unsigned athr, int unsigned ethr, int unsigned tmo,
                            int unsigned bper);
    write_reg(CFG_ALARM_THR, {6'($urandom), 10'(athr)});
    write_reg(CFG_EXIT_THR, {6'($urandom), 10'(ethr)});
    write_reg(CFG_TIMEOUT, 16'(tmo));
    write_reg(CFG_BLINK_PER, {8'($urandom), 8'(bper)});
  endtask

  task automatic drain();
    while (item_q.size() != 0 || panel_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [SmpW-1:0] pick_sample();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 3) return SmpW'($urandom);
    if (k < 5) return alarm_thr + SmpW'($urandom_range(4)) - SmpW'(2);
    if (k < 7) return exit_thr + SmpW'($urandom_range(4)) - SmpW'(2);
    if (k == 7) return '1;
    if (k == 8) return '0;
    return alarm_thr + SmpW'(1);
  endfunction

  function automatic logic [SmpW-1:0] hi_sample();
    if (alarm_thr == '1) return '1;
    return alarm_thr + SmpW'($urandom_range(1, 1023 - alarm_thr));
  endfunction

  function automatic logic [OpcodeW-1:0] pick_op();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 55) return OP_SAMPLE;
    if (k < 85) return OP_TICK;
    if (k < 95) return OP_ACK;
    return OpUnused;
  endfunction

  // mostly raise / acknowledge / time-out episodes, the rest noise
  task automatic push_random(int unsigned n);
    int unsigned goal;
    int unsigned k;
    int unsigned i;
    int unsigned span;
    goal = n_items + n;
    while (n_items < goal) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(1, 4);
        for (i = 0; i < k; i++) push_item(OP_SAMPLE, 2'($urandom), hi_sample());
        if ($urandom_range(3) != 0) push_item(OP_ACK, 2'($urandom), SmpW'($urandom));
        span = (attend_to < 40) ? attend_to + 3 : 43;
        k = $urandom_range(0, span);
        for (i = 0; i < k; i++) begin
          if ($urandom_range(9) == 0) push_item(OP_SAMPLE, 2'($urandom), pick_sample());
          else push_item(OP_TICK, 2'($urandom), SmpW'($urandom));
        end
      end else begin
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) push_item(pick_op(), 2'($urandom), pick_sample());
      end
    end
  endtask

  task automatic random_config();
    int unsigned tmo;
    int unsigned bper;
    tmo  = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(30);
    bper = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(8);
    set_config($urandom_range(1023), $urandom_range(1023), tmo, bper);
  endtask

  initial begin
    int i;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = CFG_ALARM_THR;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_SAMPLE;
    channel_i      = '0;
    sample_value_i = '0;
    out_stall_i    = 1'b0;
    in_taken       = 1'b0;
    errors         = 0;
    cycles         = 0;
    n_items        = 0;
    n_checked      = 0;
    n_writes       = 0;
    n_realarm      = 0;
    n_buzz         = 0;
    alarm_thr      = SmpW'(AlarmThrRef);
    exit_thr       = SmpW'(ExitThrRef);
    attend_to      = 16'(TimeoutReset);
    blink_per      = 8'(BlinkPerReset);
    for (i = 0; i < NumChannelsDef; i++) begin
      mode[i]    = MODE_NORMAL;
      ack_cnt[i] = '0;
    end
    blink_cnt = '0;
    blink_ph  = 1'b0;
    send_idle = 16;
    recv_idle = 55;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // directed, reset configuration
    push_item(OP_SAMPLE, 2'd0, 10'd1023);
    push_item(OP_SAMPLE, 2'd1, 10'd769);
    push_item(OP_SAMPLE, 2'd2, 10'd768);
    push_item(OP_SAMPLE, 2'd3, 10'd0);
    push_item(OP_SAMPLE, 2'd1, 10'd700);
    push_item(OP_SAMPLE, 2'd1, 10'd665);
    push_item(OP_SAMPLE, 2'd1, 10'd664);
    push_item(OP_SAMPLE, 2'd1, 10'd800);
    for (i = 0; i < 7; i++) push_item(OP_TICK, 2'd3, 10'h3FF);
    push_item(OpUnused, 2'd2, 10'd1023);
    push_item(OP_ACK, 2'd0, 10'd0);
    push_item(OP_SAMPLE, 2'd0, 10'd1023);
    push_item(OP_SAMPLE, 2'd3, 10'd900);
    push_item(OP_ACK, 2'd1, 10'h2AA);
    push_item(OP_SAMPLE, 2'd0, 10'd0);
    push_item(OP_TICK, 2'd0, 10'h155);
    drain();

    // zero timeout and zero blink period, widest hysteresis band inverted
    set_config(0, 1023, 0, 0);
    push_item(OP_SAMPLE, 2'd0, 10'd0);
    push_item(OP_SAMPLE, 2'd1, 10'd1);
    push_item(OP_SAMPLE, 2'd2, 10'd1023);
    push_item(OP_ACK, 2'd0, 10'd0);
    push_item(OP_TICK, 2'd0, 10'd0);
    push_item(OP_TICK, 2'd0, 10'd0);
    push_item(OP_TICK, 2'd0, 10'd0);
    drain();
    random_config();
    push_random(200);
    drain();

    send_idle = 55;
    recv_idle = 16;
    set_config(0, 1023, 0, 0);
    push_random(150);
    drain();
    set_config(1023, 0, 1, 255);
    push_random(150);
    drain();
    random_config();
    push_random(100);
    drain();

    send_idle = 0;
    recv_idle = 0;
    random_config();
    push_random(150);
    drain();

    // attended channel held through the timeout, then re-alarmed by the tick that reaches it
    set_config(768, 665, 40, 1);
    push_item(OP_SAMPLE, 2'd2, 10'd1023);
    push_item(OP_ACK, 2'd0, 10'd0);
    for (i = 0; i < 42; i++) push_item(OP_TICK, 2'($urandom), SmpW'($urandom));
    push_item(OP_ACK, 2'd0, 10'd0);
    drain();
    set_config(AlarmThrRef, ExitThrRef, 16'hFFFF, 8'hFF);
    push_random(50);
    drain();

    $display("Ran %0d items under %0d register writes; %0d results checked.",
             n_items, n_writes, n_checked);
    $display("Buzzer seen on in %0d results; %0d timeout re-alarms predicted.",
             n_buzz, n_realarm);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
